FILE: hdl/lrk_pkg.sv
`timescale 1ns / 1ps
package lrk_pkg;

	// fixed field widths of the stream and config ports
	localparam int NOW_W      = 48;
	localparam int FIELD_W    = 32;
	localparam int PERIOD_W   = 32;
	localparam int COUNT_W    = 32;
	localparam int SUM_W      = 64;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 232;
	localparam int OUT_PAD_W  = OUT_DATA_W - (7 * FIELD_W + 2);

	// shared add/subtract unit, wide enough for a 64-bit operand plus carry
	localparam int UNIT_W = 65;

	// divider iteration counter
	localparam int STEP_W = $clog2(SUM_W);

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;

	// item opcodes
	localparam logic OP_SLEEP   = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BACK,
		ST_DL,
		ST_SUM,
		ST_MIN,
		ST_MAX,
		ST_WAIT,
		ST_RS_ADD,
		ST_RS_CMP,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_DIV_END,
		ST_FIN
	} lrk_state_t;

endpackage

FILE: hdl/loop_rate_keeper_with_stats.sv
// channel  | dir | handshake          | payload (low bits first)
// ---------+-----+--------------------+------------------------------------------------
// s        | in  | s_tvalid/s_tready  | tdata: now_time; tuser: opcode
// m        | out | m_tvalid/m_tready  | tdata: wait, overrun, went_back, cycle, min,
//          |     |                    |        max, mean, overrun_total, cycle_total
// cfg      | in  | cfg_valid/cfg_ready| cfg_data: period_ticks
//
// an end-of-cycle item runs the back, deadline, sum, min, max and wait states, the resync
// add and compare states when it overruns, then the 64 restoring-divide steps of the mean,
// all run on the one shared add/sub unit. a restart item goes straight to the final state.
// the next item is accepted only back in idle; ready is low while an item is in work.
// a finished result sits in the output register; a new item can be accepted
// while it waits, the next result waits in the final state until the previous one is taken.
// reset is asynchronous; no clearing pass is needed.
`timescale 1ns / 1ps
module loop_rate_keeper_with_stats #(
	parameter int TIME_BITS     = 48,
	parameter int DURATION_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [47:0] now_time
	input  logic [lrk_pkg::IN_DATA_W-1:0]         s_tdata,
	// [0] opcode
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [31:0] wait_ticks, [32] overrun, [33] time_went_back, [65:34] cycle_time,
	// [97:66] min_cycle, [129:98] max_cycle, [161:130] mean_cycle,
	// [193:162] overrun_total, [225:194] cycle_total, [231:226] zero
	output logic [lrk_pkg::OUT_DATA_W-1:0]        m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lrk_pkg::PERIOD_W-1:0]          cfg_data
);

	import lrk_pkg::*;

	localparam logic [TIME_BITS-1:0]     TIME_MAX = '1;
	localparam logic [DURATION_BITS-1:0] DUR_MAX  = '1;

	lrk_state_t state_q, state_nxt;

	// configuration and statistics
	logic [PERIOD_W-1:0]      period_q;
	logic [TIME_BITS-1:0]     start_q;
	logic [SUM_W-1:0]         sum_q;
	logic [COUNT_W-1:0]       cnt_q;
	logic [COUNT_W-1:0]       ovr_cnt_q;
	logic [DURATION_BITS-1:0] min_q;
	logic [DURATION_BITS-1:0] max_q;
	logic [DURATION_BITS-1:0] mean_q;
	logic [STEP_W-1:0]        step_q;
	logic                     m_valid_q;

	// per-item working registers
	logic [TIME_BITS-1:0]     now_q;
	logic [TIME_BITS-1:0]     deadline_q;
	logic [DURATION_BITS-1:0] cyc_q;
	logic [DURATION_BITS-1:0] wait_q;
	logic                     ovr_q;
	logic                     back_q;
	logic [COUNT_W-1:0]       rem_q;
	logic [SUM_W-1:0]         div_q;
	logic [OUT_DATA_W-1:0]    out_q;

	// shared unit
	logic [UNIT_W-1:0] unit_a, unit_b;
	logic              unit_sub;
	logic [UNIT_W:0]   unit_res;
	logic              unit_borrow;
	logic              time_over;
	logic              dur_over;
	logic [TIME_BITS-1:0]     time_sat;
	logic [DURATION_BITS-1:0] dur_sat;
	logic              wait_ovr;
	logic              div_ok;

	logic accept;
	logic out_free;
	logic load_out;

	assign accept    = s_tvalid & s_tready;
	assign out_free  = ~m_valid_q | m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = out_q;

	// add/subtract unit and its saturation views
	assign unit_res    = unit_sub ? ({1'b0, unit_a} - {1'b0, unit_b})
	                              : ({1'b0, unit_a} + {1'b0, unit_b});
	assign unit_borrow = unit_res[UNIT_W];
	assign time_over   = (unit_res >> TIME_BITS) != '0;
	assign dur_over    = (unit_res[UNIT_W-1:0] >> DURATION_BITS) != '0;
	assign time_sat    = time_over ? TIME_MAX : unit_res[TIME_BITS-1:0];
	assign dur_sat     = dur_over ? DUR_MAX : unit_res[DURATION_BITS-1:0];
	assign wait_ovr    = unit_borrow | (unit_res[UNIT_W-1:0] == '0);
	assign div_ok      = ~unit_borrow;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid)
					state_nxt = (s_tuser == OP_RESTART) ? ST_FIN : ST_BACK;
			end
			ST_BACK:     state_nxt = ST_DL;
			ST_DL:       state_nxt = ST_SUM;
			ST_SUM:      state_nxt = ST_MIN;
			ST_MIN:      state_nxt = ST_MAX;
			ST_MAX:      state_nxt = ST_WAIT;
			ST_WAIT:     state_nxt = wait_ovr ? ST_RS_ADD : ST_DIV_LOAD;
			ST_RS_ADD:   state_nxt = ST_RS_CMP;
			ST_RS_CMP:   state_nxt = ST_DIV_LOAD;
			ST_DIV_LOAD: state_nxt = ST_DIV_STEP;
			ST_DIV_STEP: begin
				if (step_q == STEP_W'(SUM_W - 1))
					state_nxt = ST_DIV_END;
			end
			ST_DIV_END:  state_nxt = ST_FIN;
			ST_FIN: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// unit operand select and output load
	always_comb begin
		unit_a   = '0;
		unit_b   = '0;
		unit_sub = 1'b1;
		load_out = 1'b0;
		case (state_q)
			ST_BACK: begin
				unit_a = UNIT_W'(now_q);
				unit_b = UNIT_W'(start_q);
			end
			ST_DL: begin
				unit_a   = back_q ? UNIT_W'(now_q) : UNIT_W'(start_q);
				unit_b   = UNIT_W'(period_q);
				unit_sub = 1'b0;
			end
			ST_SUM: begin
				unit_a   = UNIT_W'(sum_q);
				unit_b   = UNIT_W'(cyc_q);
				unit_sub = 1'b0;
			end
			ST_MIN: begin
				unit_a = UNIT_W'(cyc_q);
				unit_b = UNIT_W'(min_q);
			end
			ST_MAX: begin
				unit_a = UNIT_W'(max_q);
				unit_b = UNIT_W'(cyc_q);
			end
			ST_WAIT: begin
				unit_a = UNIT_W'(deadline_q);
				unit_b = UNIT_W'(now_q);
			end
			ST_RS_ADD: begin
				unit_a   = UNIT_W'(deadline_q);
				unit_b   = UNIT_W'(period_q);
				unit_sub = 1'b0;
			end
			ST_RS_CMP: begin
				unit_a = UNIT_W'(deadline_q);
				unit_b = UNIT_W'(now_q);
			end
			ST_DIV_STEP: begin
				unit_a = UNIT_W'({rem_q, div_q[SUM_W-1]});
				unit_b = UNIT_W'(cnt_q);
			end
			ST_FIN: begin
				load_out = out_free;
			end
			default: begin
				unit_sub = 1'b1;
			end
		endcase
	end

	// control, configuration and statistics registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			period_q  <= PERIOD_RESET;
			start_q   <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			ovr_cnt_q <= '0;
			min_q     <= DUR_MAX;
			max_q     <= '0;
			mean_q    <= '0;
			step_q    <= '0;
		end else begin
			state_q <= state_nxt;

			if (cfg_valid)
				period_q <= cfg_data;

			if (load_out)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;

			// restart moves the schedule start to now
			if (accept && s_tuser == OP_RESTART)
				start_q <= TIME_BITS'(s_tdata);

			case (state_q)
				ST_SUM: begin
					sum_q <= unit_res[SUM_W] ? '1 : unit_res[SUM_W-1:0];
					if (cnt_q != '1)
						cnt_q <= cnt_q + 1'b1;
				end
				ST_MIN: begin
					if (unit_borrow)
						min_q <= cyc_q;
				end
				ST_MAX: begin
					if (unit_borrow)
						max_q <= cyc_q;
				end
				ST_WAIT: begin
					start_q <= deadline_q;
					if (wait_ovr && ovr_cnt_q != '1)
						ovr_cnt_q <= ovr_cnt_q + 1'b1;
				end
				ST_RS_CMP: begin
					// more than one extra period late: resync to now
					if (unit_borrow)
						start_q <= now_q;
				end
				ST_DIV_LOAD: begin
					step_q <= '0;
				end
				ST_DIV_STEP: begin
					step_q <= step_q + 1'b1;
				end
				ST_DIV_END: begin
					mean_q <= ((div_q >> DURATION_BITS) != '0) ? DUR_MAX
					          : div_q[DURATION_BITS-1:0];
				end
				default: begin
					step_q <= step_q;
				end
			endcase
		end
	end

	// per-item working registers and the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q  <= TIME_BITS'(s_tdata);
			cyc_q  <= '0;
			wait_q <= '0;
			ovr_q  <= 1'b0;
			back_q <= 1'b0;
		end

		case (state_q)
			ST_BACK: begin
				back_q <= unit_borrow;
				cyc_q  <= unit_borrow ? '0 : dur_sat;
			end
			ST_DL: begin
				deadline_q <= time_sat;
			end
			ST_WAIT: begin
				ovr_q  <= wait_ovr;
				wait_q <= wait_ovr ? '0 : dur_sat;
			end
			ST_RS_ADD: begin
				deadline_q <= time_sat;
			end
			ST_DIV_LOAD: begin
				rem_q <= '0;
				div_q <= sum_q;
			end
			ST_DIV_STEP: begin
				rem_q <= div_ok ? unit_res[COUNT_W-1:0] : {rem_q[COUNT_W-2:0], div_q[SUM_W-1]};
				div_q <= {div_q[SUM_W-2:0], div_ok};
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase

		if (load_out)
			out_q <= {{OUT_PAD_W{1'b0}},
			          FIELD_W'(cnt_q),
			          FIELD_W'(ovr_cnt_q),
			          FIELD_W'(mean_q),
			          FIELD_W'(max_q),
			          FIELD_W'(min_q),
			          FIELD_W'(cyc_q),
			          back_q,
			          ovr_q,
			          FIELD_W'(wait_q)};
	end

`ifndef SYNTHESIS
	// overruns are a subset of completed cycles
	a_ovr_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ovr_cnt_q <= cnt_q)
		else $error("overrun count above cycle count");

	// extremes stay ordered between items once a cycle has run
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && cnt_q != '0) |-> (min_q <= max_q))
		else $error("min cycle above max cycle");

	// the divider never runs on a zero count
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_STEP) |-> (cnt_q != '0))
		else $error("divide by zero count");

	// an accepted item always takes the block out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("ready right after accept");

	// a result is loaded only when the output register is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready && state_q == ST_FIN) |=> $stable(out_q))
		else $error("pending result overwritten");
`endif

endmodule
